/* hdl/bfpa_pkg.sv */
package bfpa_pkg;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STAT_W-1:0] ST_FREED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAIL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b1;

  localparam logic [CNT_W-1:0]  PAGES_RST = 13'd4096;
  localparam logic [ADDR_W-1:0] BASE_RST  = 32'h0020_0000;

  typedef struct packed {
    logic              opcode;
    logic [CNT_W-1:0]  page_total;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] region_address;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_MARK,
    S_ADDR,
    S_DIVGO,
    S_DIV,
    S_FEND,
    S_FRANGE,
    S_FCLR,
    S_RESP
  } state_e;

endpackage

/* hdl/bfpa_ram.sv */
module bfpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bfpa_div.sv */
module bfpa_div
  import bfpa_pkg::*;
#(
  parameter int DIVISOR = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] dividend_i,
  output logic              done_o,
  output logic [ADDR_W-1:0] quot_o
);

  // The quotient is floor(n * MAGIC / 2^QSH), exact for every 32-bit n. The
  // 33-bit MAGIC is split in two halves that share one 32 x 17 multiplier.
  localparam int SHIFT = $clog2(DIVISOR);
  localparam int QSH   = ADDR_W + SHIFT;
  localparam int MW    = ADDR_W + 1;
  localparam int LO_W  = 17;
  localparam int PW    = ADDR_W + LO_W;
  localparam int ACC_W = ADDR_W + MW;
  localparam logic [63:0] MAGIC = ((64'd1 << QSH) / 64'(DIVISOR)) + 64'd1;
  localparam logic [LO_W-1:0] M_LO = MAGIC[LO_W-1:0];
  localparam logic [LO_W-1:0] M_HI = LO_W'(MAGIC[MW-1:LO_W]);

  localparam logic [1:0] STEP_LO  = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_SUM = 2'd2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [1:0]        step_q, step_d;
  logic [ADDR_W-1:0] work_q, work_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [LO_W-1:0]   mul_b;
  logic [PW-1:0]     mul_p;
  logic [ACC_W-1:0]  quot_full;

  always_comb begin
    mul_b  = (step_q == STEP_LO) ? M_LO : M_HI;
    mul_p  = PW'(work_q) * PW'(mul_b);
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    work_d = work_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_LO;
      work_d = dividend_i;
    end else if (busy_q) begin
      unique case (step_q)
        STEP_LO: begin
          prod_d = mul_p;
          step_d = STEP_HI;
        end
        STEP_HI: begin
          acc_d  = ACC_W'(prod_q);
          prod_d = mul_p;
          step_d = STEP_SUM;
        end
        default: begin
          acc_d  = acc_q + (ACC_W'(prod_q) << LO_W);
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LO;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign quot_full = acc_q >> QSH;
  assign done_o    = done_q;
  assign quot_o    = quot_full[ADDR_W-1:0];

endmodule

/* hdl/best_fit_page_bitmap_allocator.sv */
// Best-fit page allocator over a one-bit-per-page used map held in a RAM with
// one write and one read port, both addressed by one pointer. After reset the
// block first clears the map, one page per cycle; it accepts no request
// meanwhile, but configuration writes are taken at all times. An allocate
// request scans the map one page per cycle up to the page limit, then marks the
// chosen pages one per cycle; a zero count fails without a scan. A free request
// turns the address into a page index by a reciprocal multiplication on a
// shared multiplier and then clears one page per cycle. One request is in work
// at a time; a finished result waits in the output register while the next
// request is taken.
module best_fit_page_bitmap_allocator
  import bfpa_pkg::*;
#(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int LW = (CW > CNT_W) ? CW : CNT_W;
  localparam int SW = ADDR_W + 2;
  localparam logic [ADDR_W-1:0] PAGE_W = ADDR_W'(PAGE_BYTES);

  function automatic logic [CW-1:0] clamp_f(input logic signed [SW-1:0] v,
                                            input logic signed [SW-1:0] lim_s,
                                            input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v[SW-1]) begin
      r = '0;
    end else if (v > lim_s) begin
      r = lim;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [CNT_W-1:0]  pages_q;
  logic [ADDR_W-1:0] base_q;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  out_item_t         pend_q, pend_d;

  logic [CW-1:0]     lim_q, lim_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     end_q, end_d;
  logic              rd_vld_q, rd_vld_d;
  logic [CW-1:0]     rd_pos_q, rd_pos_d;
  logic [CW-1:0]     run_len_q, run_len_d;
  logic [CW-1:0]     run_start_q, run_start_d;
  logic              found_q, found_d;
  logic [CW-1:0]     best_q, best_d;
  logic [CW-1:0]     best_len_q, best_len_d;
  logic [ADDR_W-1:0] prod_q, prod_d;
  logic [ADDR_W:0]   diff_q, diff_d;
  logic signed [SW-1:0] idx_q, idx_d;
  logic signed [SW-1:0] end_s_q, end_s_d;

  logic [LW-1:0]        pages_ext;
  logic [CW-1:0]        lim_now;
  logic signed [SW-1:0] lim_s;
  logic signed [SW-1:0] q_ext;
  logic                 scan_rd;
  logic                 close_run;
  logic                 fits;

  logic              ram_we;
  logic              ram_wdata;
  logic              ram_rdata;
  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;

  bfpa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_PAGES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bfpa_div #(
    .DIVISOR(PAGE_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign pages_ext = LW'(pages_q);
  assign lim_now   = (pages_ext > LW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pages_q);
  assign lim_s     = SW'(lim_q);
  assign q_ext     = SW'(div_quot);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pend_d      = pend_q;
    lim_d       = lim_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    rd_vld_d    = 1'b0;
    rd_pos_d    = rd_pos_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    found_d     = found_q;
    best_d      = best_q;
    best_len_d  = best_len_q;
    prod_d      = prod_q;
    diff_d      = diff_q;
    idx_d       = idx_q;
    end_s_d     = end_s_q;
    ram_we      = 1'b0;
    ram_wdata   = 1'b0;
    div_start   = 1'b0;
    div_dividend = diff_q[ADDR_W] ? (~diff_q[ADDR_W-1:0] + ADDR_W'(1))
                                  : diff_q[ADDR_W-1:0];
    scan_rd     = (ptr_q < lim_q);
    close_run   = 1'b0;
    fits        = (LW'(run_len_q) >= LW'(count_q)) &&
                  (!found_q || (run_len_q < best_len_q));

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + CW'(1);
        if (ptr_q == CW'(MAX_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          lim_d   = lim_now;
          count_d = in_item_i.page_total;
          if (in_item_i.opcode == OP_ALLOC) begin
            if (in_item_i.page_total == '0) begin
              pend_d  = '{region_address: '0, status: ST_FAIL};
              state_d = S_RESP;
            end else begin
              ptr_d     = '0;
              run_len_d = '0;
              found_d   = 1'b0;
              state_d   = S_SCAN;
            end
          end else begin
            diff_d  = {1'b0, in_item_i.free_address} - {1'b0, base_q};
            state_d = S_DIVGO;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          if (!ram_rdata) begin
            if (run_len_q == '0) begin
              run_start_d = rd_pos_q;
            end
            run_len_d = run_len_q + CW'(1);
          end else begin
            close_run = 1'b1;
            run_len_d = '0;
          end
        end else if (!scan_rd) begin
          close_run = 1'b1;
          state_d   = S_PICK;
        end
        if (close_run && fits) begin
          found_d    = 1'b1;
          best_d     = run_start_q;
          best_len_d = run_len_q;
        end
        if (scan_rd) begin
          ptr_d    = ptr_q + CW'(1);
          rd_vld_d = 1'b1;
          rd_pos_d = ptr_q;
        end
      end
      S_PICK: begin
        if (!found_q) begin
          pend_d  = '{region_address: '0, status: ST_FAIL};
          state_d = S_RESP;
        end else begin
          ptr_d   = best_q;
          end_d   = best_q + CW'(count_q);
          prod_d  = ADDR_W'(best_q) * PAGE_W;
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        if (ptr_q < end_q) begin
          ram_we    = 1'b1;
          ram_wdata = 1'b1;
          ptr_d     = ptr_q + CW'(1);
        end else begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        pend_d  = '{region_address: base_q + prod_q, status: ST_ALLOC};
        state_d = S_RESP;
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          idx_d   = diff_q[ADDR_W] ? -q_ext : q_ext;
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        end_s_d = idx_q + SW'(count_q);
        ptr_d   = clamp_f(idx_q, lim_s, lim_q);
        state_d = S_FRANGE;
      end
      S_FRANGE: begin
        end_d   = clamp_f(end_s_q, lim_s, lim_q);
        state_d = S_FCLR;
      end
      S_FCLR: begin
        if (ptr_q < end_q) begin
          ram_we = 1'b1;
          ptr_d  = ptr_q + CW'(1);
        end else begin
          pend_d  = '{region_address: '0, status: ST_FREED};
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      pages_q     <= PAGES_RST;
      base_q      <= BASE_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PAGES: pages_q <= cfg_data_i[CNT_W-1:0];
          CFG_BASE:  base_q  <= cfg_data_i;
          default:   pages_q <= pages_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    pend_q      <= pend_d;
    lim_q       <= lim_d;
    count_q     <= count_d;
    end_q       <= end_d;
    rd_pos_q    <= rd_pos_d;
    run_len_q   <= run_len_d;
    run_start_q <= run_start_d;
    best_q      <= best_d;
    best_len_q  <= best_len_d;
    prod_q      <= prod_d;
    diff_q      <= diff_d;
    idx_q       <= idx_d;
    end_s_q     <= end_s_d;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("request taken while the previous one is still in work");

  a_addr_zero_unless_alloc: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_ALLOC) |-> out_item_o.region_address == '0
  ) else $error("nonzero address on a free or failed result");

  a_write_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ptr_q < CW'(MAX_PAGES)
  ) else $error("map write beyond the last page");
`endif

endmodule
